// ===== src/cov3d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3d_pkg
// Shared widths, constants, command/status structs and helper functions of
// the 3D point covariance block.
// ----------------------------------------------------------------------------
package cov3d_pkg;

  // Set size limit and the number of used coordinate bits.
  localparam int MAX_POINTS = 65536;
  localparam int COORD_BITS = 16;

  // Port and state widths.
  localparam int COORD_W = 16;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUM_W   = 33;
  localparam int PSUM_W  = 48;
  localparam int RES_W   = 32;

  // Finalize arithmetic widths.
  localparam int ACC_W   = 64;
  localparam int DSQ_W   = 2 * CNT_W;
  localparam int MPL_W   = SUM_W;
  localparam int ITER_W  = $clog2(ACC_W + 1);

  localparam int NUM_AXES    = 3;
  localparam int NUM_ENTRIES = 6;
  localparam int IDX_W       = 3;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // Entry order: xx, xy, xz, yy, yz, zz.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  typedef struct packed {
    logic                 accept;
    logic                 mul_load_sq;
    logic                 mul_load_n;
    logic                 mul_load_ss;
    logic                 mul_step;
    logic                 mul_sub;
    logic                 sq_save;
    logic                 div_load;
    logic                 div_step;
    logic                 res_store;
    logic                 publish;
    logic                 centered;
    logic [IDX_W-1:0]     idx;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } status_t;

  function automatic logic [1:0] pair_a(input logic [IDX_W-1:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [IDX_W-1:0] k);
    logic [1:0] r;
    case (k)
      3'd0:       r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  // Two's complement value of the low COORD_BITS bits.
  function automatic logic signed [COORD_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] t;
    t = $signed(v << (COORD_W - COORD_BITS));
    return t >>> (COORD_W - COORD_BITS);
  endfunction

endpackage

// ===== src/cov3d_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3d_ctrl
// Sequencer: point intake, pipeline drain, per-entry multiply and divide
// steps, and hand-off of the finished result.
// ----------------------------------------------------------------------------
module cov3d_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_point_i,
  input  logic                centered_i,
  input  cov3d_pkg::status_t  status_i,
  output logic                in_ready_o,
  output cov3d_pkg::cmd_t     cmd_o
);

  typedef enum logic [9:0] {
    ST_ACCUM = 10'b0000000001,
    ST_DRAIN = 10'b0000000010,
    ST_SQR   = 10'b0000000100,
    ST_SQSV  = 10'b0000001000,
    ST_NUM1  = 10'b0000010000,
    ST_NUM2  = 10'b0000100000,
    ST_DLOAD = 10'b0001000000,
    ST_DIV   = 10'b0010000000,
    ST_FIX   = 10'b0100000000,
    ST_PUB   = 10'b1000000000
  } state_e;

  state_e                           state_q, state_d;
  logic [cov3d_pkg::ITER_W-1:0]     iter_q, iter_d;
  logic [cov3d_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                             accept;

  assign in_ready_o = (state_q == ST_ACCUM);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    iter_d  = '0;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.accept   = accept;
    cmd_o.centered = centered_i;
    cmd_o.idx      = idx_q;
    case (state_q)
      ST_ACCUM: begin
        if (accept && last_point_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          if (centered_i) begin
            state_d = ST_DLOAD;
          end else begin
            cmd_o.mul_load_sq = 1'b1;
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        cmd_o.mul_step = 1'b1;
        if (iter_q == cov3d_pkg::ITER_W'(cov3d_pkg::CNT_W - 1)) begin
          state_d = ST_SQSV;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ST_SQSV: begin
        cmd_o.sq_save    = 1'b1;
        cmd_o.mul_load_n = 1'b1;
        state_d = ST_NUM1;
      end
      ST_NUM1: begin
        cmd_o.mul_step = 1'b1;
        if (iter_q == cov3d_pkg::ITER_W'(cov3d_pkg::CNT_W - 1)) begin
          cmd_o.mul_load_ss = 1'b1;
          state_d = ST_NUM2;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ST_NUM2: begin
        // Subtract the low partial products, add back the sign-weighted top one.
        cmd_o.mul_step = 1'b1;
        if (iter_q == cov3d_pkg::ITER_W'(cov3d_pkg::MPL_W - 1)) begin
          state_d = ST_DLOAD;
        end else begin
          cmd_o.mul_sub = 1'b1;
          iter_d = iter_q + 1'b1;
        end
      end
      ST_DLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (iter_q == cov3d_pkg::ITER_W'(cov3d_pkg::ACC_W - 1)) begin
          state_d = ST_FIX;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ST_FIX: begin
        cmd_o.res_store = 1'b1;
        if (idx_q == cov3d_pkg::LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_PUB;
        end else begin
          idx_d = idx_q + 1'b1;
          if (centered_i) begin
            state_d = ST_DLOAD;
          end else begin
            cmd_o.mul_load_n = 1'b1;
            state_d = ST_NUM1;
          end
        end
        // Advance the loads to the next entry.
        cmd_o.idx = idx_d;
      end
      ST_PUB: begin
        if (!status_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      iter_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== src/cov3d_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3d_dp
// Datapath: two-stage product pipeline with sum accumulators, a shift-add
// multiplier, a restoring divider and the result registers.
// ----------------------------------------------------------------------------
module cov3d_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cov3d_pkg::cmd_t                        cmd_i,
  input  logic        [cov3d_pkg::COORD_W-1:0]   point_x_i,
  input  logic        [cov3d_pkg::COORD_W-1:0]   point_y_i,
  input  logic        [cov3d_pkg::COORD_W-1:0]   point_z_i,
  input  logic                                   out_ready_i,
  output cov3d_pkg::status_t                     status_o,
  output logic                                   out_valid_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     var_xx_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     cov_xy_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     cov_xz_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     var_yy_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     cov_yz_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     var_zz_o,
  output logic                                   count_overflow_o
);

  localparam int CW  = cov3d_pkg::COORD_W;
  localparam int PW  = cov3d_pkg::PROD_W;
  localparam int SW  = cov3d_pkg::SUM_W;
  localparam int QW  = cov3d_pkg::PSUM_W;
  localparam int NW  = cov3d_pkg::CNT_W;
  localparam int AW  = cov3d_pkg::ACC_W;
  localparam int DW  = cov3d_pkg::DSQ_W;
  localparam int MW  = cov3d_pkg::MPL_W;
  localparam int RW  = cov3d_pkg::RES_W;
  localparam int NE  = cov3d_pkg::NUM_ENTRIES;
  localparam int NA  = cov3d_pkg::NUM_AXES;

  // Intake and product pipeline
  logic signed [CW-1:0] a_c_q [NA];
  logic signed [CW-1:0] b_c_q [NA];
  logic signed [PW-1:0] prod_d [NE];
  logic signed [PW-1:0] prod_q [NE];
  logic                 a_valid_q, b_valid_q;
  logic                 take;

  // Accumulators
  logic [NW-1:0]        count_q;
  logic                 ovf_q;
  logic signed [SW-1:0] cs_q [NA];
  logic signed [QW-1:0] ps_q [NE];

  // Finalize
  logic signed [SW-1:0] si, sj;
  logic signed [QW-1:0] psel;
  logic [AW-1:0]        mcand_q, mcand_d;
  logic [MW-1:0]        mplier_q, mplier_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [AW-1:0]        term;
  logic [DW-1:0]        dsq_q;
  logic [AW-1:0]        num_src, mag;
  logic [AW-1:0]        dq_q;
  logic [DW-1:0]        rem_q;
  logic [DW-1:0]        dvs_q;
  logic                 neg_q;
  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 ge;
  logic [AW-1:0]        qfix;
  logic [RW-1:0]        res_q [NE];
  logic [RW-1:0]        out_q [NE];
  logic                 out_ovf_q;
  logic                 out_valid_q;

  assign take = (count_q < cov3d_pkg::MAX_CNT);

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      prod_d[k] = a_c_q[cov3d_pkg::pair_a(3'(k))] * a_c_q[cov3d_pkg::pair_b(3'(k))];
    end
  end

  // Hold control flags and counters under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      a_valid_q <= cmd_i.accept & take;
      b_valid_q <= a_valid_q;
      if (cmd_i.publish) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.accept) begin
        if (take) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_c_q[0] <= cov3d_pkg::sext_coord(point_x_i);
      a_c_q[1] <= cov3d_pkg::sext_coord(point_y_i);
      a_c_q[2] <= cov3d_pkg::sext_coord(point_z_i);
    end
    b_c_q  <= a_c_q;
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) cs_q[k] <= '0;
      for (int k = 0; k < NE; k++) ps_q[k] <= '0;
    end else if (cmd_i.publish) begin
      for (int k = 0; k < NA; k++) cs_q[k] <= '0;
      for (int k = 0; k < NE; k++) ps_q[k] <= '0;
    end else if (b_valid_q) begin
      for (int k = 0; k < NA; k++) begin
        cs_q[k] <= cs_q[k] + {{(SW-CW){b_c_q[k][CW-1]}}, b_c_q[k]};
      end
      for (int k = 0; k < NE; k++) begin
        ps_q[k] <= ps_q[k] + {{(QW-PW){prod_q[k][PW-1]}}, prod_q[k]};
      end
    end
  end

  // Operand select for the current entry
  always_comb begin
    case (cov3d_pkg::pair_a(cmd_i.idx))
      2'd0:    si = cs_q[0];
      2'd1:    si = cs_q[1];
      default: si = cs_q[2];
    endcase
    case (cov3d_pkg::pair_b(cmd_i.idx))
      2'd0:    sj = cs_q[0];
      2'd1:    sj = cs_q[1];
      default: sj = cs_q[2];
    endcase
    psel = ps_q[cmd_i.idx];
  end

  // Shift-add multiplier, one multiplier bit per step
  always_comb begin
    term = mplier_q[0] ? mcand_q : '0;
    acc_d = acc_q;
    if (cmd_i.mul_load_sq || cmd_i.mul_load_n) begin
      acc_d = '0;
    end else if (cmd_i.mul_step) begin
      acc_d = cmd_i.mul_sub ? (acc_q - term) : (acc_q + term);
    end
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (cmd_i.mul_load_sq) begin
      mcand_d  = {{(AW-NW){1'b0}}, count_q};
      mplier_d = {{(MW-NW){1'b0}}, count_q};
    end else if (cmd_i.mul_load_n) begin
      mcand_d  = {{(AW-QW){psel[QW-1]}}, psel};
      mplier_d = {{(MW-NW){1'b0}}, count_q};
    end else if (cmd_i.mul_load_ss) begin
      mcand_d  = {{(AW-SW){si[SW-1]}}, si};
      mplier_d = sj;
    end else if (cmd_i.mul_step) begin
      mcand_d  = {mcand_q[AW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[MW-1:1]};
    end
  end

  // Restoring divider on the magnitude, floor fixed afterwards
  always_comb begin
    num_src = cmd_i.centered ? {{(AW-QW){psel[QW-1]}}, psel} : acc_q;
    mag     = num_src[AW-1] ? (~num_src + 1'b1) : num_src;
    trial   = {rem_q, dq_q[AW-1]};
    ge      = (trial >= {1'b0, dvs_q});
    diff    = trial - {1'b0, dvs_q};
    qfix    = neg_q ? (~(dq_q + {{(AW-1){1'b0}}, (rem_q != '0)}) + 1'b1) : dq_q;
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    if (cmd_i.sq_save) begin
      dsq_q <= acc_q[DW-1:0];
    end
    if (cmd_i.div_load) begin
      dq_q  <= mag;
      neg_q <= num_src[AW-1];
      rem_q <= '0;
      dvs_q <= cmd_i.centered ? {{(DW-NW){1'b0}}, count_q} : dsq_q;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[AW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
    // Entries finish in order xx..zz; shift each in at the top.
    if (cmd_i.res_store) begin
      for (int k = 0; k < NE - 1; k++) res_q[k] <= res_q[k+1];
      res_q[NE-1] <= (count_q == '0) ? '0 : qfix[RW-1:0];
    end
    if (cmd_i.publish) begin
      out_q     <= res_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.pipe_busy = a_valid_q | b_valid_q;
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign var_xx_o         = out_q[0];
  assign cov_xy_o         = out_q[1];
  assign cov_xz_o         = out_q[2];
  assign var_yy_o         = out_q[3];
  assign cov_yz_o         = out_q[4];
  assign var_zz_o         = out_q[5];
  assign count_overflow_o = out_ovf_q;

endmodule

// ===== src/covariance_3d_points.sv =====
`timescale 1ns / 1ps
// Finalizing starts on the marked point: with mean removal the bit-serial
//   multiplier and the divider both work on each of the six entries;
//   in centered mode only the divider does.
// Throughput: one point per cycle inside a set; intake pauses while a set is
//   being finalized. Reset clears the mode register and all accumulators.
// ----------------------------------------------------------------------------
// covariance_3d_points
// Covariance matrix of a set of 3D points: accumulates count, coordinate sums
// and product sums, then forms the six distinct entries on the marked point.
// ----------------------------------------------------------------------------
module covariance_3d_points (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration: mode register, written without handshake
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_wdata_i,
  // Point requests
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [cov3d_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [cov3d_pkg::COORD_W-1:0]   point_y_i,
  input  logic signed [cov3d_pkg::COORD_W-1:0]   point_z_i,
  input  logic                                   last_point_i,
  // Result requests
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cov3d_pkg::RES_W-1:0]     var_xx_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     cov_xy_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     cov_xz_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     var_yy_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     cov_yz_o,
  output logic signed [cov3d_pkg::RES_W-1:0]     var_zz_o,
  output logic                                   count_overflow_o
);

  // Mode register: 1 takes the product sums as already centered (Sij / n),
  // 0 removes the mean exactly ((n*Sij - Si*Sj) / n^2).
  logic               centered_q;
  cov3d_pkg::cmd_t    cmd;
  cov3d_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centered_q <= 1'b0;
    end else if (cfg_we_i) begin
      centered_q <= cfg_wdata_i;
    end
  end

  // Controller: accepts points while accumulating, then drains the product
  // pipeline and steps the shared multiplier and divider through the entries.
  cov3d_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .centered_i   (centered_q),
    .status_i     (status),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  // Datapath: sums, arithmetic units and the output register, which holds a
  // finished result while the next set is already being accumulated.
  cov3d_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .point_z_i        (point_z_i),
    .out_ready_i      (out_ready_i),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .var_xx_o         (var_xx_o),
    .cov_xy_o         (cov_xy_o),
    .cov_xz_o         (cov_xz_o),
    .var_yy_o         (var_yy_o),
    .cov_yz_o         (cov_yz_o),
    .var_zz_o         (var_zz_o),
    .count_overflow_o (count_overflow_o)
  );

endmodule
